>>> sv/isodir_pkg.sv
package isodir_pkg;

    // Longest target name that the compare logic honors.
    localparam int NAME_CHARS = 12;

    // Record layout and name delimiters.
    localparam logic [7:0] POS_NAME_LEN  = 8'd32;
    localparam logic [7:0] POS_NAME_BASE = 8'd33;
    localparam logic [7:0] POS_LBA_FIRST  = 8'd2;
    localparam logic [7:0] POS_LBA_LAST   = 8'd5;
    localparam logic [7:0] POS_SIZE_FIRST = 8'd10;
    localparam logic [7:0] POS_SIZE_LAST  = 8'd13;
    localparam logic [7:0] CHAR_SEMI      = 8'h3B;
    localparam logic [7:0] CHAR_NUL       = 8'h00;

    // Configuration register indexes.
    localparam logic [1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [1:0] REG_NAME_HIGH = 2'd1;
    localparam logic [1:0] REG_NAME_LEN  = 2'd2;

    // Reset values of the target name ("GAME.ELF").
    localparam logic [63:0] RST_NAME_LOW  = 64'd5065499745918468423;
    localparam logic [31:0] RST_NAME_HIGH = 32'd0;
    localparam logic [3:0]  RST_NAME_LEN  = 4'd8;

    typedef struct packed {
        logic [63:0] low;
        logic [31:0] high;
        logic [3:0]  len;
    } t_target;

    typedef struct packed {
        logic [7:0] dir_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic        found;
        logic [31:0] extent_lba;
        logic [31:0] extent_size;
    } t_result;

    // Map upper-case ASCII letters onto lower case.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // Target length, saturated to the supported name size.
    function automatic logic [3:0] target_len(input t_target t);
        logic [3:0] r;
        r = t.len;
        if (t.len > 4'(NAME_CHARS)) begin
            r = 4'(NAME_CHARS);
        end
        return r;
    endfunction

    // Character idx of the target; positions past byte 11 read as zero.
    function automatic logic [7:0] target_char(input t_target t, input logic [3:0] idx);
        logic [95:0] all;
        logic [6:0]  off;
        logic [7:0]  r;
        all = {t.high, t.low};
        off = {idx, 3'b000};
        r   = 8'h00;
        if (idx < 4'd12) begin
            r = all[off +: 8];
        end
        return r;
    endfunction

endpackage

>>> sv/isodir_if.sv
// Directory byte stream channel.
interface isodir_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] dir_byte;
    logic       last_byte;

    modport source (output valid, output dir_byte, output last_byte, input ready);
    modport sink   (input valid, input dir_byte, input last_byte, output ready);
endinterface

// Lookup result channel.
interface isodir_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] extent_lba;
    logic [31:0] extent_size;

    modport source (output valid, output found, output extent_lba, output extent_size,
                    input ready);
    modport sink   (input valid, input found, input extent_lba, input extent_size,
                    output ready);
endinterface

// Configuration write channel.
interface isodir_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/isodir_cfg.sv
module isodir_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    isodir_cfg_if.sink           i_cfg,
    output isodir_pkg::t_target  o_target
);

    isodir_pkg::t_target r_target;

    // Writes are always taken: ready is tied high.
    assign i_cfg.ready = 1'b1;

    // Register file for the target name.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target.low  <= isodir_pkg::RST_NAME_LOW;
            r_target.high <= isodir_pkg::RST_NAME_HIGH;
            r_target.len  <= isodir_pkg::RST_NAME_LEN;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                isodir_pkg::REG_NAME_LOW: begin
                    r_target.low <= i_cfg.data;
                end
                isodir_pkg::REG_NAME_HIGH: begin
                    r_target.high <= i_cfg.data[31:0];
                end
                isodir_pkg::REG_NAME_LEN: begin
                    r_target.len <= i_cfg.data[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_target = r_target;

endmodule

>>> sv/isodir_in_reg.sv
module isodir_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    isodir_byte_if.sink        i_dir,
    input  logic               i_advance,
    output logic               o_step,
    output isodir_pkg::t_item  o_item
);

    logic               r_valid;
    isodir_pkg::t_item  r_item;

    // The held byte is consumed whenever the result side has room.
    assign o_step      = r_valid && i_advance;
    assign i_dir.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_dir.ready) begin
            r_valid <= i_dir.valid;
        end
    end

    // Payload capture on each input transfer.
    always_ff @(posedge i_clk) begin
        if (i_dir.valid && i_dir.ready) begin
            r_item.dir_byte  <= i_dir.dir_byte;
            r_item.last_byte <= i_dir.last_byte;
        end
    end

    assign o_item = r_item;

endmodule

>>> sv/isodir_walk.sv
module isodir_walk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  isodir_pkg::t_item    i_item,
    input  isodir_pkg::t_target  i_target,
    output logic                 o_emit,
    output isodir_pkg::t_result  o_result
);

    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_rlen, n_rlen;
    logic [7:0]  r_nfl, n_nfl;
    logic [3:0]  r_matched, n_matched;
    logic        r_mis, n_mis;
    logic        r_term, n_term;
    logic [31:0] r_lba, n_lba;
    logic [31:0] r_size, n_size;
    logic        r_done, n_done;

    logic [7:0]  b;
    logic [3:0]  tlen;
    logic [7:0]  tchar;
    logic [8:0]  pos_inc;
    logic [7:0]  k;
    logic [1:0]  sel;
    logic        stop_emit;
    logic        hit;

    assign b     = i_item.dir_byte;
    assign tlen  = isodir_pkg::target_len(i_target);
    assign tchar = isodir_pkg::target_char(i_target, r_matched);
    assign pos_inc = {1'b0, r_pos} + 9'd1;
    assign k       = r_pos - isodir_pkg::POS_NAME_BASE;
    // Byte lane within the little-endian address and length fields.
    assign sel     = r_pos[1:0] - 2'd2;

    // Record walk and name compare for one directory byte.
    always_comb begin
        n_pos     = r_pos;
        n_rlen    = r_rlen;
        n_nfl     = r_nfl;
        n_matched = r_matched;
        n_mis     = r_mis;
        n_term    = r_term;
        n_lba     = r_lba;
        n_size    = r_size;
        n_done    = r_done;
        stop_emit = 1'b0;
        hit       = 1'b0;

        if (!r_done) begin
            if (r_pos == 8'd0) begin
                // A zero byte at record start is padding.
                if (b != 8'd0) begin
                    n_rlen    = b;
                    n_nfl     = 8'd0;
                    n_matched = 4'd0;
                    n_mis     = 1'b0;
                    n_term    = 1'b0;
                    n_pos     = (b == 8'd1) ? 8'd0 : 8'd1;
                end
            end else begin
                if (r_pos >= isodir_pkg::POS_LBA_FIRST && r_pos <= isodir_pkg::POS_LBA_LAST) begin
                    n_lba[{sel, 3'b000} +: 8] = b;
                end
                if (r_pos >= isodir_pkg::POS_SIZE_FIRST &&
                    r_pos <= isodir_pkg::POS_SIZE_LAST) begin
                    n_size[{sel, 3'b000} +: 8] = b;
                end
                if (r_pos == isodir_pkg::POS_NAME_LEN) begin
                    n_nfl = b;
                    // An empty name ends the scan.
                    if (b == 8'd0) begin
                        stop_emit = 1'b1;
                    end
                end else if (r_pos >= isodir_pkg::POS_NAME_BASE && k < r_nfl) begin
                    if (r_nfl == 8'd1) begin
                        // Single-byte names other than the dot entries end the scan.
                        if (b > 8'd1) begin
                            stop_emit = 1'b1;
                        end
                    end else if (!r_term) begin
                        if (b == isodir_pkg::CHAR_SEMI || b == isodir_pkg::CHAR_NUL) begin
                            n_term = 1'b1;
                            if (!r_mis && r_matched == tlen) begin
                                stop_emit = 1'b1;
                                hit       = 1'b1;
                            end
                        end else begin
                            if (!r_mis) begin
                                if (r_matched >= tlen ||
                                    isodir_pkg::fold_case(b) != isodir_pkg::fold_case(tchar)) begin
                                    n_mis = 1'b1;
                                end else begin
                                    n_matched = r_matched + 4'd1;
                                end
                            end
                            if (({1'b0, k} + 9'd1) == {1'b0, r_nfl} &&
                                !n_mis && n_matched == tlen) begin
                                stop_emit = 1'b1;
                                hit       = 1'b1;
                            end
                        end
                    end
                end
                n_pos = (pos_inc >= {1'b0, r_rlen}) ? 8'd0 : pos_inc[7:0];
            end
        end

        if (stop_emit) begin
            n_done = 1'b1;
        end

        o_emit               = stop_emit || (i_item.last_byte && !r_done);
        o_result.found       = hit;
        o_result.extent_lba  = hit ? n_lba : 32'd0;
        o_result.extent_size = hit ? n_size : 32'd0;

        // The final byte of the extent re-arms the walk for the next directory.
        if (i_item.last_byte) begin
            n_pos     = 8'd0;
            n_rlen    = 8'd0;
            n_nfl     = 8'd0;
            n_matched = 4'd0;
            n_mis     = 1'b0;
            n_term    = 1'b0;
            n_lba     = 32'd0;
            n_size    = 32'd0;
            n_done    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 8'd0;
            r_rlen    <= 8'd0;
            r_nfl     <= 8'd0;
            r_matched <= 4'd0;
            r_mis     <= 1'b0;
            r_term    <= 1'b0;
            r_lba     <= 32'd0;
            r_size    <= 32'd0;
            r_done    <= 1'b0;
        end else if (i_step) begin
            r_pos     <= n_pos;
            r_rlen    <= n_rlen;
            r_nfl     <= n_nfl;
            r_matched <= n_matched;
            r_mis     <= n_mis;
            r_term    <= n_term;
            r_lba     <= n_lba;
            r_size    <= n_size;
            r_done    <= n_done;
        end
    end

endmodule

>>> sv/isodir_out_reg.sv
module isodir_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  isodir_pkg::t_result  i_result,
    output logic                 o_advance,
    isodir_res_if.source         o_res
);

    logic                 r_valid;
    isodir_pkg::t_result  r_result;

    // Room for a new result when empty or when the held one leaves this cycle.
    assign o_advance = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.found       = r_result.found;
    assign o_res.extent_lba  = r_result.extent_lba;
    assign o_res.extent_size = r_result.extent_size;

endmodule

>>> sv/iso9660_directory_search.sv
// Channel   Role    Payload                                    Transfer when
// i_dir     sink    dir_byte[7:0], last_byte                   valid && ready
// o_res     source  found, extent_lba[31:0], extent_size[31:0] valid && ready
// i_cfg     sink    index[1:0], data[63:0]                     valid && ready (ready tied high)
//
// One directory byte is taken every cycle while the input register is empty or its byte
// is consumed. A byte is walked while it sits in the input register, and any result it
// decides is loaded into the output register as the byte leaves the input register.
// The output register holds one result; a held byte stalls only while that result is
// held and not taken. Synchronous active-low reset restores the default target name
// and starts a fresh directory scan.
module iso9660_directory_search (
    input  logic         i_clk,
    input  logic         i_rst_n,
    isodir_byte_if.sink  i_dir,
    isodir_res_if.source o_res,
    isodir_cfg_if.sink   i_cfg
);

    isodir_pkg::t_target target;
    isodir_pkg::t_item   item;
    isodir_pkg::t_result result;
    logic                step;
    logic                advance;
    logic                emit;

    isodir_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_target (target)
    );

    isodir_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dir     (i_dir),
        .i_advance (advance),
        .o_step    (step),
        .o_item    (item)
    );

    isodir_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (item),
        .i_target (target),
        .o_emit   (emit),
        .o_result (result)
    );

    isodir_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (step && emit),
        .i_result  (result),
        .o_advance (advance),
        .o_res     (o_res)
    );

endmodule

>>> tb/tb_top.sv
module tb_top;
    import isodir_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int RUN_LIMIT     = 5_000_000;

    // Kinds of directory record that the random part builds.
    typedef enum logic [3:0] {
        REC_MATCH,
        REC_PREFIX,
        REC_LONGER,
        REC_FLIP,
        REC_RANDOM,
        REC_SHORT,
        REC_STOP_EMPTY,
        REC_STOP_ONE,
        REC_DOT
    } t_entry_kind;

    logic i_clk;
    logic i_rst_n;

    isodir_byte_if dir_if ();
    isodir_res_if  res_if ();
    isodir_cfg_if  cfg_if ();

    iso9660_directory_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dir   (dir_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Target name as the block should hold it.
    logic [63:0] tgt_low  = RST_NAME_LOW;
    logic [31:0] tgt_high = RST_NAME_HIGH;
    logic [3:0]  tgt_len  = RST_NAME_LEN;

    // Record walk state of the lookup predictor.
    logic [7:0]  rec_pos      = 8'd0;
    logic [7:0]  rec_len      = 8'd0;
    logic [7:0]  name_field   = 8'd0;
    logic [7:0]  name_hits    = 8'd0;
    logic        name_bad     = 1'b0;
    logic        name_cut     = 1'b0;
    logic [31:0] cap_lba      = 32'd0;
    logic [31:0] cap_size     = 32'd0;
    logic        dir_answered = 1'b0;

    t_item       extent_bytes[$];
    t_result     pending_lookups[$];
    logic [7:0]  dir_build[$];
    logic [7:0]  name_build[$];

    int          errors         = 0;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          bytes_queued   = 0;
    int          dirs_queued    = 0;
    bit          byte_taken     = 1'b0;
    bit          hold_armed     = 1'b0;
    bit          hold_done      = 1'b0;
    int          hold_cycles    = 0;

    // Target length as the compare honors it.
    function automatic int unsigned target_size();
        return (tgt_len > 4'(NAME_CHARS)) ? NAME_CHARS : int'(tgt_len);
    endfunction

    function automatic logic [7:0] target_byte(input int unsigned i);
        logic [95:0] both;
        both = {tgt_high, tgt_low};
        if (i >= 12) begin
            return 8'h00;
        end
        return both[8*i +: 8];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
    endfunction

    function automatic bit name_equal();
        return !name_bad && int'(name_hits) == target_size();
    endfunction

    function automatic void restart_directory();
        rec_pos      = 8'd0;
        rec_len      = 8'd0;
        name_field   = 8'd0;
        name_hits    = 8'd0;
        name_bad     = 1'b0;
        name_cut     = 1'b0;
        cap_lba      = 32'd0;
        cap_size     = 32'd0;
        dir_answered = 1'b0;
    endfunction

    // Walks one directory byte; returns 1 when the byte produces a lookup result.
    function automatic bit walk_byte(input logic [7:0] b, input logic last,
                                     output t_result r);
        logic [7:0] p;
        logic [7:0] k;
        bit         answered_before;
        bit         emit;
        bit         hit;
        answered_before = dir_answered;
        emit = 1'b0;
        hit  = 1'b0;
        p    = rec_pos;
        if (!dir_answered) begin
            if (p == 8'd0) begin
                // A zero length byte is padding between records.
                if (b != 8'd0) begin
                    rec_len    = b;
                    name_field = 8'd0;
                    name_hits  = 8'd0;
                    name_bad   = 1'b0;
                    name_cut   = 1'b0;
                    rec_pos    = (b <= 8'd1) ? 8'd0 : 8'd1;
                end
            end else begin
                if (p >= POS_LBA_FIRST && p <= POS_LBA_LAST) begin
                    cap_lba[8*(p-2) +: 8] = b;
                end
                if (p >= POS_SIZE_FIRST && p <= POS_SIZE_LAST) begin
                    cap_size[8*(p-10) +: 8] = b;
                end
                if (p == POS_NAME_LEN) begin
                    name_field = b;
                    if (b == 8'd0) begin
                        emit = 1'b1;
                    end
                end else if (p >= POS_NAME_BASE && (p - POS_NAME_BASE) < name_field) begin
                    k = p - POS_NAME_BASE;
                    if (name_field == 8'd1) begin
                        // One-character names other than the dot codes end the scan.
                        if (b != 8'd0 && b != 8'd1) begin
                            emit = 1'b1;
                        end
                    end else if (!name_cut) begin
                        if (b == CHAR_SEMI || b == CHAR_NUL) begin
                            name_cut = 1'b1;
                            if (name_equal()) begin
                                emit = 1'b1;
                                hit  = 1'b1;
                            end
                        end else begin
                            if (!name_bad) begin
                                if (int'(name_hits) >= target_size() ||
                                    to_lower(b) != to_lower(target_byte(name_hits))) begin
                                    name_bad = 1'b1;
                                end else begin
                                    name_hits = name_hits + 8'd1;
                                end
                            end
                            if (k + 8'd1 == name_field && name_equal()) begin
                                emit = 1'b1;
                                hit  = 1'b1;
                            end
                        end
                    end
                end
                rec_pos = (int'(p) + 1 >= int'(rec_len)) ? 8'd0 : p + 8'd1;
            end
        end
        if (emit) begin
            dir_answered = 1'b1;
        end
        if (last && !emit && !answered_before) begin
            emit = 1'b1;
        end
        r.found       = hit;
        r.extent_lba  = hit ? cap_lba : 32'd0;
        r.extent_size = hit ? cap_size : 32'd0;
        if (last) begin
            restart_directory();
        end
        return emit;
    endfunction

    // Moves the built directory into the byte queue, last byte flagged.
    function automatic void flush_directory();
        t_item it;
        foreach (dir_build[i]) begin
            it.dir_byte  = dir_build[i];
            it.last_byte = (i == dir_build.size() - 1);
            extent_bytes.push_back(it);
        end
        bytes_queued += dir_build.size();
        dirs_queued++;
        dir_build.delete();
    endfunction

    // Appends one record; a length below 33 plus the name size cuts it short.
    function automatic void add_record(input int unsigned full_len, input logic [7:0] field_len,
                                       input logic [31:0] lba, input logic [31:0] size);
        logic [7:0] v;
        for (int i = 0; i < full_len; i++) begin
            v = 8'($urandom);
            if (i == 0) begin
                v = 8'(full_len);
            end else if (i >= 2 && i <= 5) begin
                v = lba[8*(i-2) +: 8];
            end else if (i >= 10 && i <= 13) begin
                v = size[8*(i-10) +: 8];
            end else if (i == 32) begin
                v = field_len;
            end else if (i >= 33 && i - 33 < name_build.size()) begin
                v = name_build[i-33];
            end
            dir_build.push_back(v);
        end
    endfunction

    function automatic void set_name(input string s);
        name_build.delete();
        foreach (s[i]) begin
            name_build.push_back(s[i]);
        end
    endfunction

    function automatic void add_named(input string s, input logic [31:0] lba,
                                      input logic [31:0] size);
        set_name(s);
        add_record(33 + s.len(), 8'(s.len()), lba, size);
    endfunction

    // Target name spelled in random letter case.
    function automatic void spell_target(input int unsigned count);
        logic [7:0] c;
        name_build.delete();
        for (int i = 0; i < count; i++) begin
            c = target_byte(i);
            if (to_lower(c) >= "a" && to_lower(c) <= "z" && $urandom_range(1) == 1) begin
                c = c ^ 8'h20;
            end
            name_build.push_back(c);
        end
    endfunction

    // Optional version suffix or NUL cut after the name.
    function automatic void add_suffix();
        int unsigned pick;
        pick = $urandom_range(2);
        if (pick == 1) begin
            name_build.push_back(CHAR_SEMI);
            name_build.push_back("1");
        end else if (pick == 2) begin
            name_build.push_back(CHAR_NUL);
            name_build.push_back(8'($urandom));
        end
    endfunction

    function automatic t_entry_kind pick_kind();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35) return REC_MATCH;
        if (r < 45) return REC_PREFIX;
        if (r < 53) return REC_LONGER;
        if (r < 61) return REC_FLIP;
        if (r < 73) return REC_RANDOM;
        if (r < 81) return REC_SHORT;
        if (r < 86) return REC_STOP_EMPTY;
        if (r < 91) return REC_STOP_ONE;
        return REC_DOT;
    endfunction

    function automatic void add_entry(input t_entry_kind kind);
        int unsigned n;
        int unsigned full;
        logic [7:0]  c;
        n = target_size();
        case (kind)
            REC_MATCH: begin
                spell_target(n);
                add_suffix();
            end
            REC_PREFIX: begin
                spell_target((n == 0) ? 0 : $urandom_range(n - 1));
                add_suffix();
            end
            REC_LONGER: begin
                spell_target(n);
                c = 8'($urandom_range(1, 255));
                name_build.push_back((c == CHAR_SEMI) ? 8'h3A : c);
                add_suffix();
            end
            REC_FLIP: begin
                spell_target(n);
                if (n != 0) begin
                    c = 8'($urandom_range(n - 1));
                    name_build[c] = name_build[c] ^ 8'h20;
                end
                add_suffix();
            end
            REC_RANDOM: begin
                name_build.delete();
                repeat ($urandom_range(2, 14)) name_build.push_back(8'($urandom));
            end
            REC_STOP_EMPTY: begin
                name_build.delete();
            end
            REC_STOP_ONE: begin
                name_build.delete();
                name_build.push_back(8'($urandom_range(2, 255)));
            end
            REC_DOT: begin
                name_build.delete();
                name_build.push_back(8'($urandom_range(1)));
            end
            default: begin
                spell_target(n);
                add_suffix();
            end
        endcase
        full = 33 + name_build.size() + $urandom_range(3);
        if (full > 255) begin
            full = 255;
        end
        if (kind == REC_SHORT) begin
            full = $urandom_range(1, full - 1);
        end
        add_record(full, 8'(name_build.size()), $urandom, $urandom);
    endfunction

    // One random directory: mostly well formed, some raw noise, some cut early.
    function automatic void add_directory();
        int unsigned last_kept;
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 40)) begin
                dir_build.push_back(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
            end
        end else begin
            if ($urandom_range(99) < 20) begin
                add_entry(REC_DOT);
                add_entry(REC_DOT);
            end
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(3) == 0) begin
                    repeat ($urandom_range(1, 3)) dir_build.push_back(8'h00);
                end
                add_entry(pick_kind());
            end
            if ($urandom_range(9) == 0) begin
                last_kept = $urandom_range(dir_build.size() - 1);
                dir_build = dir_build[0:last_kept];
            end
        end
        flush_directory();
    endfunction

    function automatic void queue_random(input int min_dirs, input int min_bytes);
        bytes_queued = 0;
        dirs_queued  = 0;
        do begin
            add_directory();
        end while (dirs_queued < min_dirs || bytes_queued < min_bytes);
    endfunction

    // Hand-built directories against the default target name.
    function automatic void queue_directed();
        // Lower-case match with all-ones address and size; the bytes after it are ignored.
        add_named("game.elf;1", 32'hFFFFFFFF, 32'hFFFFFFFF);
        repeat (3) dir_build.push_back(8'($urandom));
        flush_directory();
        // An empty name stops the scan.
        add_named("", 32'hF, 32'h10);
        flush_directory();
        // Both dot entries are skipped, then a one-character name stops the scan.
        name_build = '{8'h00};
        add_record(34, 8'd1, 32'h1, 32'h800);
        name_build = '{8'h01};
        add_record(34, 8'd1, 32'h2, 32'h800);
        add_named("A", 32'h13, 32'h14);
        flush_directory();
        // A lone zero byte forms a whole directory.
        dir_build.push_back(8'h00);
        flush_directory();
        // A one-byte record, then a mixed-case match that completes on the final byte.
        dir_build.push_back(8'd1);
        add_named("Game.Elf", 32'h80000001, 32'h7FFFFFFF);
        flush_directory();
    endfunction

    function automatic logic [63:0] name_chars();
        logic [63:0] v;
        for (int i = 0; i < 8; i++) begin
            v[8*i +: 8] = ($urandom_range(4) == 0) ? 8'h2E : 8'($urandom_range(8'h41, 8'h5A));
        end
        return v;
    endfunction

    // Sender and receiver idling for one of the three traffic modes.
    function automatic void set_idling(input int mode);
        if (mode == 0) begin
            src_idle_pct   = 27;
            sink_stall_pct = 58;
        end else if (mode == 1) begin
            src_idle_pct   = 58;
            sink_stall_pct = 27;
        end else begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
        end
    endfunction

    // Configuration write, one transfer on the register channel.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_NAME_LOW:  tgt_low  = value;
            REG_NAME_HIGH: tgt_high = value[31:0];
            REG_NAME_LEN:  tgt_len  = value[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Waits until every byte is sent and every lookup result has come back.
    task automatic wait_idle();
        while (extent_bytes.size() != 0 || dir_if.valid || pending_lookups.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Result checking and lookup prediction at each rising edge.
    always @(posedge i_clk) begin
        t_result want;
        t_result calc;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (pending_lookups.size() == 0) begin
                    $error("unexpected result: found=%0d extent_lba=%h extent_size=%h",
                           res_if.found, res_if.extent_lba, res_if.extent_size);
                    errors++;
                end else begin
                    want = pending_lookups.pop_front();
                    if (res_if.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, res_if.found);
                        errors++;
                    end
                    if (res_if.extent_lba !== want.extent_lba) begin
                        $error("extent_lba: expected %h, got %h",
                               want.extent_lba, res_if.extent_lba);
                        errors++;
                    end
                    if (res_if.extent_size !== want.extent_size) begin
                        $error("extent_size: expected %h, got %h",
                               want.extent_size, res_if.extent_size);
                        errors++;
                    end
                end
            end
            if (dir_if.valid && dir_if.ready) begin
                byte_taken = 1'b1;
                if (walk_byte(dir_if.dir_byte, dir_if.last_byte, calc)) begin
                    pending_lookups.push_back(calc);
                end
            end
        end
    end

    // Byte driver: holds each byte until its transfer, idles at random between bytes.
    always @(negedge i_clk) begin
        t_item it;
        if (i_rst_n && (!dir_if.valid || byte_taken)) begin
            if (extent_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                it = extent_bytes.pop_front();
                dir_if.valid     <= 1'b1;
                dir_if.dir_byte  <= it.dir_byte;
                dir_if.last_byte <= it.last_byte;
            end else begin
                dir_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started once on request.
    always @(negedge i_clk) begin
        if (hold_armed && !hold_done) begin
            hold_cycles <= LONG_HOLD;
            hold_done   <= 1'b1;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Result receiver with random stalls.
    always @(negedge i_clk) begin
        res_if.ready <= (hold_cycles == 0) && ($urandom_range(99) >= sink_stall_pct);
    end

    // Stimulus in phases, one target setting per phase.
    initial begin
        logic [63:0] chars;
        i_rst_n          = 1'b0;
        dir_if.valid     = 1'b0;
        dir_if.dir_byte  = 8'h00;
        dir_if.last_byte = 1'b0;
        res_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_NAME_LOW;
        cfg_if.data      = 64'd0;
        restart_directory();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    chars = name_chars();
                    write_reg(REG_NAME_LOW, chars);
                    chars = name_chars();
                    write_reg(REG_NAME_HIGH, {$urandom, chars[31:0]});
                    write_reg(REG_NAME_LEN, {$urandom, 28'($urandom), 4'd12});
                end
                2: begin
                    write_reg(REG_NAME_LOW, {64{1'b1}});
                    write_reg(REG_NAME_HIGH, {64{1'b1}});
                    write_reg(REG_NAME_LEN, {64{1'b1}});
                end
                3: begin
                    write_reg(REG_NAME_LOW, 64'd0);
                    write_reg(REG_NAME_HIGH, 64'd0);
                    write_reg(REG_NAME_LEN, 64'd0);
                end
                4: begin
                    write_reg(REG_NAME_LOW, name_chars());
                    write_reg(REG_NAME_HIGH, {32'd0, $urandom});
                    write_reg(REG_NAME_LEN, 64'd1);
                end
                5: begin
                    write_reg(REG_NAME_LOW, {$urandom, $urandom});
                    write_reg(REG_NAME_HIGH, {$urandom, $urandom});
                    write_reg(REG_NAME_LEN, 64'($urandom_range(1, NAME_CHARS)));
                end
                default: ;
            endcase
            @(posedge i_clk);
            set_idling(phase / 2);
            if (phase == 0) begin
                queue_directed();
            end else begin
                if (phase == 1) begin
                    // Back-to-back one-byte directories while the receiver holds off.
                    repeat (20) begin
                        dir_build.push_back(8'($urandom));
                        flush_directory();
                    end
                    hold_armed = 1'b1;
                end
                queue_random(1, 1);
            end
            wait_idle();
        end

        if (pending_lookups.size() != 0) begin
            $error("%0d lookup results never arrived", pending_lookups.size());
            errors++;
        end
        if (errors == 0) begin
            $display("[iso9660_directory_search] OK");
        end else begin
            $display("[iso9660_directory_search] ERROR");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #RUN_LIMIT;
        $display("[iso9660_directory_search] ERROR");
        $finish;
    end

endmodule

>>> iso9660_directory_search.f
sv/isodir_pkg.sv
sv/isodir_if.sv
sv/isodir_cfg.sv
sv/isodir_in_reg.sv
sv/isodir_walk.sv
sv/isodir_out_reg.sv
sv/iso9660_directory_search.sv
tb/tb_top.sv
